[hdl/clcdtc_pkg.sv]
package clcdtc_pkg;

	// Request kinds
	localparam logic [2:0] KIND_PRINT = 3'd0;
	localparam logic [2:0] KIND_RAW   = 3'd1;
	localparam logic [2:0] KIND_GOTO  = 3'd2;
	localparam logic [2:0] KIND_CLEAR = 3'd3;
	localparam logic [2:0] KIND_HOME  = 3'd4;
	localparam logic [2:0] KIND_INIT  = 3'd5;

	// Controller command bytes
	localparam logic [7:0] CMD_CLEAR     = 8'h01;
	localparam logic [7:0] CMD_HOME      = 8'h02;
	localparam logic [7:0] CMD_DISPLAY   = 8'h0f;
	localparam logic [7:0] CMD_FUNC_SET  = 8'h2f;
	localparam logic [7:0] FUNC_8BIT     = 8'h10;
	localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
	localparam logic [7:0] ROW_OFFSET    = 8'h40;

	// Characters with special meaning
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_LF    = 8'h0a;
	localparam logic [7:0] CHAR_CR    = 8'h0d;

	// Index of the last init step
	localparam logic [2:0] INIT_LAST_STEP = 3'd4;

	// Datapath operations issued by the controller
	typedef enum logic [2:0] {
		OP_NOP,
		OP_CMD,
		OP_GLYPH,
		OP_NL,
		OP_CR,
		OP_GOTO,
		OP_SROW,
		OP_SCELL
	} op_t;

	typedef struct packed {
		logic       load;
		op_t        op;
		logic [7:0] cmd_byte;
		logic       last;
		logic       zero_cursor;
		logic       blank;
	} dp_cmd_t;

	typedef struct packed {
		logic last_col;
		logic last_row;
		logic scan_col_last;
		logic scan_row_last;
	} dp_status_t;

endpackage

[hdl/clcdtc_ram.sv]
module clcdtc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[hdl/clcdtc_dp.sv]
module clcdtc_dp #(
	parameter int ROWS = 2,
	parameter int COLS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [7:0]             char_code,
	input  logic [7:0]             col,
	input  logic [7:0]             row,
	input  clcdtc_pkg::dp_cmd_t    cmd,
	output clcdtc_pkg::dp_status_t status,
	output logic                   strobe,
	output logic                   is_data,
	output logic [7:0]             bus_byte,
	output logic                   last
);

	localparam int DEPTH = ROWS * COLS;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(COLS);
	localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;

	// latched request fields
	logic [7:0]       char_q;
	logic [7:0]       col_in_q;
	logic [7:0]       row_in_q;

	// cursor and scroll scan position
	logic [CW-1:0]    cur_col_q;
	logic [RW-1:0]    cur_row_q;
	logic [CW-1:0]    scan_col_q;
	logic [RW-1:0]    scan_row_q;

	// shadow entry written since last blank; unwritten reads as space
	logic [DEPTH-1:0] valid_q;

	// stage 1: memory read in flight, beat being formed
	logic             emit_s1;
	logic             is_data_s1;
	logic [7:0]       byte_s1;
	logic             last_s1;
	logic             cell_s1;
	logic             blank_s1;
	logic             wr_s1;
	logic [AW-1:0]    waddr_s1;
	logic             rvalid_s1;

	// output beat
	logic             strobe_q;
	logic             is_data_q;
	logic [7:0]       bus_byte_q;
	logic             last_q;

	logic [CW-1:0]    goto_col;
	logic [RW-1:0]    goto_row;
	logic [AW-1:0]    cur_addr;
	logic [AW-1:0]    rd_addr;
	logic [AW-1:0]    cell_addr;
	logic [7:0]       cell_val;
	logic             ram_we;
	logic [7:0]       ram_wdata;
	logic [7:0]       ram_rdata;
	logic             scan_col_last;
	logic             scan_row_last;

	// set-address command for column x, row y
	function automatic logic [7:0] cursor_cmd(input logic [7:0] x, input logic [1:0] y);
		logic [7:0] a;
		a = x;
		if ((ROWS == 2 || ROWS == 4) && y[0]) begin
			a = a + clcdtc_pkg::ROW_OFFSET;
		end
		if (ROWS == 4 && y[1]) begin
			a = a + 8'(COLS);
		end
		return clcdtc_pkg::CMD_SET_DDRAM | a;
	endfunction

	// addresses, clamps and scroll status
	always_comb begin
		goto_col      = (col_in_q >= 8'(COLS)) ? CW'(COLS - 1) : col_in_q[CW-1:0];
		goto_row      = (row_in_q >= 8'(ROWS)) ? RW'(ROWS - 1) : row_in_q[RW-1:0];
		cur_addr      = AW'(int'(cur_row_q) * COLS + int'(cur_col_q));
		cell_addr     = AW'(int'(scan_row_q) * COLS + int'(scan_col_q));
		scan_col_last = (scan_col_q == CW'(COLS - 1));
		scan_row_last = (scan_row_q == RW'(ROWS - 1));
		// scroll reads the cell one row below the one being rewritten
		rd_addr       = scan_row_last ? '0 :
			AW'((int'(scan_row_q) + 1) * COLS + int'(scan_col_q));
	end

	assign status.last_col      = (cur_col_q == CW'(COLS - 1));
	assign status.last_row      = (cur_row_q == RW'(ROWS - 1));
	assign status.scan_col_last = scan_col_last;
	assign status.scan_row_last = scan_row_last;

	// stage 1 write back into the shadow
	assign cell_val  = (blank_s1 || !rvalid_s1) ? clcdtc_pkg::CHAR_SPACE : ram_rdata;
	assign ram_we    = wr_s1 | cell_s1;
	assign ram_wdata = cell_s1 ? cell_val : byte_s1;

	clcdtc_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_shadow (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr_s1),
		.wdata (ram_wdata),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	// cursor, scan counters, valid bits, beat strobes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q  <= '0;
			cur_row_q  <= '0;
			scan_col_q <= '0;
			scan_row_q <= '0;
			valid_q    <= '0;
			emit_s1    <= 1'b0;
			cell_s1    <= 1'b0;
			wr_s1      <= 1'b0;
			strobe_q   <= 1'b0;
		end else begin
			case (cmd.op)
				clcdtc_pkg::OP_GLYPH: begin
					if (status.last_col) begin
						cur_col_q <= '0;
						if (!status.last_row) begin
							cur_row_q <= cur_row_q + 1'b1;
						end
					end else begin
						cur_col_q <= cur_col_q + 1'b1;
					end
				end
				clcdtc_pkg::OP_NL: begin
					cur_row_q <= cur_row_q + 1'b1;
				end
				clcdtc_pkg::OP_CR: begin
					cur_col_q <= '0;
				end
				clcdtc_pkg::OP_GOTO: begin
					cur_col_q <= goto_col;
					cur_row_q <= goto_row;
				end
				clcdtc_pkg::OP_CMD: begin
					if (cmd.zero_cursor) begin
						cur_col_q <= '0;
						cur_row_q <= '0;
					end
				end
				clcdtc_pkg::OP_SCELL: begin
					if (scan_col_last) begin
						scan_col_q <= '0;
						scan_row_q <= scan_row_last ? '0 : scan_row_q + 1'b1;
					end else begin
						scan_col_q <= scan_col_q + 1'b1;
					end
				end
				default: begin
				end
			endcase

			if (cmd.op == clcdtc_pkg::OP_CMD && cmd.blank) begin
				valid_q <= '0;
			end else if (ram_we) begin
				valid_q[waddr_s1] <= 1'b1;
			end

			emit_s1  <= (cmd.op != clcdtc_pkg::OP_NOP) && (cmd.op != clcdtc_pkg::OP_NL);
			cell_s1  <= (cmd.op == clcdtc_pkg::OP_SCELL);
			wr_s1    <= (cmd.op == clcdtc_pkg::OP_GLYPH);
			strobe_q <= emit_s1;
		end
	end

	// payload: request latch, stage 1 beat, output beat
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			char_q   <= char_code;
			col_in_q <= col;
			row_in_q <= row;
		end

		case (cmd.op)
			clcdtc_pkg::OP_GLYPH: byte_s1 <= char_q;
			clcdtc_pkg::OP_CR:    byte_s1 <= cursor_cmd(8'd0, 2'(cur_row_q));
			clcdtc_pkg::OP_GOTO:  byte_s1 <= cursor_cmd(8'(goto_col), 2'(goto_row));
			clcdtc_pkg::OP_SROW:  byte_s1 <= cursor_cmd(8'd0, 2'(scan_row_q));
			default:              byte_s1 <= cmd.cmd_byte;
		endcase
		is_data_s1 <= (cmd.op == clcdtc_pkg::OP_GLYPH) || (cmd.op == clcdtc_pkg::OP_SCELL);
		last_s1    <= cmd.last;
		blank_s1   <= scan_row_last;
		waddr_s1   <= (cmd.op == clcdtc_pkg::OP_GLYPH) ? cur_addr : cell_addr;
		rvalid_s1  <= valid_q[rd_addr];

		is_data_q  <= is_data_s1;
		bus_byte_q <= cell_s1 ? cell_val : byte_s1;
		last_q     <= last_s1;
	end

	assign strobe   = strobe_q;
	assign is_data  = is_data_q;
	assign bus_byte = bus_byte_q;
	assign last     = last_q;

endmodule

[hdl/clcdtc_ctrl.sv]
module clcdtc_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [2:0]             kind,
	input  logic [7:0]             char_code,
	input  logic                   cfg_valid,
	input  logic                   cfg_data,
	output logic                   busy,
	output clcdtc_pkg::dp_cmd_t    cmd,
	input  clcdtc_pkg::dp_status_t status
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_GLYPH,
		S_NL,
		S_CR,
		S_SROW,
		S_SCELL,
		S_GOTO,
		S_CMD,
		S_INIT
	} state_t;

	state_t     state_q;
	logic [2:0] step_q;
	logic [7:0] cmd_byte_q;
	logic       blank_q;
	logic       bus_8bit_q;
	logic       accept;

	assign busy   = (state_q != S_IDLE);
	assign accept = start & ~busy;

	// byte of each init step
	function automatic logic [7:0] init_byte(input logic [2:0] step, input logic b8);
		logic [7:0] b;
		unique case (step)
			3'd0:    b = b8 ? (clcdtc_pkg::CMD_FUNC_SET | clcdtc_pkg::FUNC_8BIT)
				: clcdtc_pkg::CMD_FUNC_SET;
			3'd1:    b = clcdtc_pkg::CMD_DISPLAY;
			3'd2:    b = clcdtc_pkg::CMD_CLEAR;
			3'd3:    b = clcdtc_pkg::CMD_DISPLAY;
			default: b = clcdtc_pkg::CMD_HOME;
		endcase
		return b;
	endfunction

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			step_q     <= '0;
			cmd_byte_q <= '0;
			blank_q    <= 1'b0;
			bus_8bit_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				bus_8bit_q <= cfg_data;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (kind)
							clcdtc_pkg::KIND_PRINT: begin
								if (char_code == clcdtc_pkg::CHAR_LF) begin
									state_q <= status.last_row ? S_SROW : S_NL;
								end else if (char_code == clcdtc_pkg::CHAR_CR) begin
									state_q <= S_CR;
								end else begin
									state_q <= S_GLYPH;
								end
							end
							clcdtc_pkg::KIND_RAW:  state_q <= S_GLYPH;
							clcdtc_pkg::KIND_GOTO: state_q <= S_GOTO;
							clcdtc_pkg::KIND_CLEAR: begin
								state_q    <= S_CMD;
								cmd_byte_q <= clcdtc_pkg::CMD_CLEAR;
								blank_q    <= 1'b1;
							end
							clcdtc_pkg::KIND_HOME: begin
								state_q    <= S_CMD;
								cmd_byte_q <= clcdtc_pkg::CMD_HOME;
								blank_q    <= 1'b0;
							end
							clcdtc_pkg::KIND_INIT: begin
								state_q <= S_INIT;
								step_q  <= '0;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_GLYPH: begin
					if (status.last_col) begin
						state_q <= status.last_row ? S_SROW : S_CR;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_NL:   state_q <= S_CR;
				S_CR:   state_q <= S_IDLE;
				S_SROW: state_q <= S_SCELL;
				S_SCELL: begin
					if (status.scan_col_last) begin
						state_q <= status.scan_row_last ? S_CR : S_SROW;
					end
				end
				S_GOTO: state_q <= S_IDLE;
				S_CMD:  state_q <= S_IDLE;
				S_INIT: begin
					if (step_q == clcdtc_pkg::INIT_LAST_STEP) begin
						state_q <= S_IDLE;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath command for the current state
	always_comb begin
		cmd             = '0;
		cmd.op          = clcdtc_pkg::OP_NOP;
		cmd.load        = accept;
		unique case (state_q)
			S_GLYPH: begin
				cmd.op   = clcdtc_pkg::OP_GLYPH;
				cmd.last = ~status.last_col;
			end
			S_NL: cmd.op = clcdtc_pkg::OP_NL;
			S_CR: begin
				cmd.op   = clcdtc_pkg::OP_CR;
				cmd.last = 1'b1;
			end
			S_SROW:  cmd.op = clcdtc_pkg::OP_SROW;
			S_SCELL: cmd.op = clcdtc_pkg::OP_SCELL;
			S_GOTO: begin
				cmd.op   = clcdtc_pkg::OP_GOTO;
				cmd.last = 1'b1;
			end
			S_CMD: begin
				cmd.op          = clcdtc_pkg::OP_CMD;
				cmd.cmd_byte    = cmd_byte_q;
				cmd.last        = 1'b1;
				cmd.zero_cursor = 1'b1;
				cmd.blank       = blank_q;
			end
			S_INIT: begin
				cmd.op          = clcdtc_pkg::OP_CMD;
				cmd.cmd_byte    = init_byte(step_q, bus_8bit_q);
				cmd.last        = (step_q == clcdtc_pkg::INIT_LAST_STEP);
				cmd.zero_cursor = (step_q == clcdtc_pkg::INIT_LAST_STEP);
				cmd.blank       = (step_q == clcdtc_pkg::INIT_LAST_STEP);
			end
			default: begin
			end
		endcase
	end

endmodule

[hdl/char_lcd_text_console_core.sv]
// Text console for a character LCD: keeps a shadow screen and cursor and
// turns each request into controller bus writes.
// Request channel: a request is taken on a clock edge with start high and
// busy low; kind, char_code, col and row are sampled there.
// Result channel: each bus write is shown for one cycle with strobe high
// (is_data, bus_byte, last); last marks the final write of a request.
// Config channel: cfg_data sets the 8-bit bus flag on an edge with
// cfg_valid high; cfg_ready is always high. Write it only while idle.
// The first write of a request passes the sequencer state, stage 1 and
// the output beat register before it is strobed; later writes follow one
// per cycle, except that a newline moving down a row has a silent S_NL step.
// Busy stays high while the sequencer steps through a request, and a new
// request is taken only once it is idle; earlier writes may still be in flight.
// A printed character that wraps on the last row scrolls and gives
// 2 + ROWS*(COLS+1) writes: 36 writes at 2x16. The sequencer
// issues one datapath step per cycle; the shadow RAM has one read and one
// write port, and scroll copies one cell per cycle.
// Unused kinds are accepted and give no writes.
// Reset: cursor home, shadow all spaces (per-entry valid bits, no sweep),
// 4-bit bus flag. The receiver cannot stall, so no backpressure exists.
module char_lcd_text_console_core #(
	parameter int ROWS = 2,
	parameter int COLS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [2:0] kind,
	input  logic [7:0] char_code,
	input  logic [7:0] col,
	input  logic [7:0] row,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_data,
	output logic       strobe,
	output logic       is_data,
	output logic [7:0] bus_byte,
	output logic       last
);

	clcdtc_pkg::dp_cmd_t    cmd;
	clcdtc_pkg::dp_status_t status;

	assign cfg_ready = 1'b1;

	clcdtc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.kind      (kind),
		.char_code (char_code),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.busy      (busy),
		.cmd       (cmd),
		.status    (status)
	);

	clcdtc_dp #(
		.ROWS (ROWS),
		.COLS (COLS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_code (char_code),
		.col       (col),
		.row       (row),
		.cmd       (cmd),
		.status    (status),
		.strobe    (strobe),
		.is_data   (is_data),
		.bus_byte  (bus_byte),
		.last      (last)
	);

endmodule
